>>> src/assert_macros.svh
// Assertion macros used by the RTL core of the timed event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> src/tesq_pkg.sv
// Types and constants of the timed event sorted queue.
`timescale 1ns / 1ps

package tesq_pkg;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_READ     = 2'd2,
        KIND_RELOAD   = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    localparam int             PROD_W          = 25;
    localparam logic [16:0]    SECONDS_PER_DAY = 17'd86400;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] event_time;
        logic [15:0] event_depth;
        logic [7:0]  repeat_days;
        logic [7:0]  entry_index;
        logic [7:0]  slots_loaded;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [7:0]  insert_position;
        logic [31:0] head_time;
        logic [31:0] read_time;
        logic [15:0] read_depth;
        logic [7:0]  read_repeat;
        logic [5:0]  entry_count;
        logic [7:0]  next_slot;
        logic        slot_available;
    } t_out_beat;

    // One stored event
    typedef struct packed {
        logic [31:0] ev_time;
        logic [15:0] ev_depth;
        logic [7:0]  ev_rep;
    } t_entry;

    // Completion report of the list sequencer
    typedef struct packed {
        logic        done;
        t_status     status;
        logic [7:0]  insert_position;
        logic [31:0] head_time;
        t_entry      rd_entry;
    } t_list_rsp;

endpackage

>>> src/timed_event_sorted_queue_core.sv
// Timed event sorted queue: handshake, slot counter and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Keeps up to LIST_DEPTH events sorted by time, earliest first.
// Input channel (i_in_valid / o_in_stall / i_in_beat): one beat is one operation:
// add an event, complete the head, read an entry or reload the slot count.
// Output channel (o_out_valid / i_out_stall / o_out_beat): one result beat per
// input beat, in order, with the head time, entry count and slot state.
// The block works on one beat at a time; o_in_stall is high from acceptance
// until the result is loaded into the output register. One write port, one
// registered read port and a single time comparator do the work, one entry
// per cycle: an add moves up every entry placed after the new event; a
// complete moves every remaining entry down and, when the event repeats,
// inserts it again at its next occurrence. Reload, a full add and an empty
// complete or read only fetch the head for the report.
// The result register lets a new beat in while the previous result waits;
// a stalled receiver holds the next result inside the list until it drains.
// Reset empties the list, sets the slot counter to 2 and the loaded slots to
// MAX_SLOTS; the entry memory itself is not cleared.
module timed_event_sorted_queue_core import tesq_pkg::*; #(
    parameter int LIST_DEPTH = 32,
    parameter int MAX_SLOTS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int         CW           = $clog2(LIST_DEPTH + 1);
    localparam logic [7:0] MAX_SLOTS_B  = 8'(MAX_SLOTS);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_BUSY = 2'b10
    } t_top_state;

    t_top_state     r_state, n_state;
    t_in_beat       r_req;
    logic [7:0]     r_slot_ctr, n_slot_ctr;
    logic [7:0]     r_slots, n_slots;
    logic           r_out_valid;
    t_out_beat      r_out, n_out;

    logic           w_in_acc;
    logic           w_rsp_ready;
    t_list_rsp      w_rsp;
    logic [CW-1:0]  w_count;

    assign o_in_stall  = (r_state != T_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_rsp_ready = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    tesq_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc),
        .i_req       (i_in_beat),
        .i_rsp_ready (w_rsp_ready),
        .o_rsp       (w_rsp),
        .o_count     (w_count)
    );

    // Advance the control state, the slot counter and the loaded slots, build the result beat
    always_comb begin
        n_state    = r_state;
        n_slot_ctr = r_slot_ctr;
        n_slots    = r_slots;

        unique case (r_state)
            T_IDLE: begin
                if (w_in_acc) begin
                    n_state = T_BUSY;
                end
            end
            T_BUSY: begin
                if (w_rsp.done) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase

        if (w_rsp.done) begin
            if (r_req.kind == KIND_COMPLETE && w_rsp.status == STAT_OK
                    && r_slot_ctr != 8'hFF) begin
                n_slot_ctr = r_slot_ctr + 8'd1;
            end
            if (r_req.kind == KIND_RELOAD) begin
                n_slots    = (r_req.slots_loaded > MAX_SLOTS_B) ? MAX_SLOTS_B
                                                                : r_req.slots_loaded;
                n_slot_ctr = 8'd1;
            end
        end

        n_out.status          = w_rsp.status;
        n_out.insert_position = w_rsp.insert_position;
        n_out.head_time       = w_rsp.head_time;
        n_out.read_time       = w_rsp.rd_entry.ev_time;
        n_out.read_depth      = w_rsp.rd_entry.ev_depth;
        n_out.read_repeat     = w_rsp.rd_entry.ev_rep;
        n_out.entry_count     = 6'(w_count);
        n_out.next_slot       = n_slot_ctr;
        n_out.slot_available  = (n_slot_ctr <= n_slots);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_slot_ctr  <= 8'd2;
            r_slots     <= MAX_SLOTS_B;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot_ctr <= n_slot_ctr;
            r_slots    <= n_slots;
            if (w_rsp.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        // Hold the accepted beat and the pending result
        if (w_in_acc) begin
            r_req <= i_in_beat;
        end
        if (w_rsp.done) begin
            r_out <= n_out;
        end
    end

    `ASSERT_ALWAYS(a_done_while_busy, i_clk, i_rst_n, w_rsp.done |-> (r_state == T_BUSY))
    `ASSERT_NEVER(a_count_overflow, i_clk, i_rst_n, w_count > CW'(LIST_DEPTH))
    `ASSERT_ALWAYS(a_slot_flag, i_clk, i_rst_n, o_out_valid |-> (o_out_beat.slot_available == (o_out_beat.next_slot <= r_slots)))

endmodule

>>> src/tesq_list.sv
// Sorted event list: entry memory, compare/shift sequencer and repeat-time unit.
`timescale 1ns / 1ps

module tesq_list import tesq_pkg::*; #(
    parameter int LIST_DEPTH = 32,
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_in_beat      i_req,
    input  logic          i_rsp_ready,
    output t_list_rsp     o_rsp,
    output logic [CW-1:0] o_count
);

    localparam int AW = $clog2(LIST_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_INS      = 10'b0000000010,
        S_SHIFT    = 10'b0000000100,
        S_POP_HEAD = 10'b0000001000,
        S_POP      = 10'b0000010000,
        S_MUL      = 10'b0000100000,
        S_ADD      = 10'b0001000000,
        S_RD_WAIT  = 10'b0010000000,
        S_HEAD     = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    t_entry              r_new, n_new;
    t_entry              r_rd, n_rd;
    logic [7:0]          r_pos, n_pos;
    t_status             r_status, n_status;
    logic                r_is_add, n_is_add;
    logic [PROD_W-1:0]   r_prod, n_prod;

    t_entry              mem [LIST_DEPTH];
    t_entry              r_q;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    t_entry              w_wdata;

    logic [CW-1:0]       w_cm1, w_km1, w_km2, w_kp1;
    logic [8:0]          w_idx_ext, w_cnt_ext, w_rd_idx;

    // Neighbor indexes of the scan pointer and the entry count, and the clamped read index
    assign w_cm1     = r_count - CW'(1);
    assign w_km1     = r_k - CW'(1);
    assign w_km2     = r_k - CW'(2);
    assign w_kp1     = r_k + CW'(1);
    assign w_idx_ext = {1'b0, i_req.entry_index};
    assign w_cnt_ext = 9'(r_count);
    assign w_rd_idx  = (w_idx_ext >= w_cnt_ext) ? (w_cnt_ext - 9'd1) : w_idx_ext;

    assign o_count = r_count;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_q <= mem[w_raddr];
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_new    = r_new;
        n_rd     = r_rd;
        n_pos    = r_pos;
        n_status = r_status;
        n_is_add = r_is_add;
        n_prod   = r_prod;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = r_new;
        w_raddr  = '0;
        o_rsp.done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = STAT_OK;
                    n_is_add = (i_req.kind == KIND_ADD);
                    n_pos    = '0;
                    n_rd     = '0;
                    unique case (i_req.kind)
                        KIND_ADD: begin
                            if (r_count == CW'(LIST_DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = S_HEAD;
                            end else begin
                                n_new.ev_time  = i_req.event_time;
                                n_new.ev_depth = i_req.event_depth;
                                n_new.ev_rep   = i_req.repeat_days;
                                n_state        = S_INS;
                            end
                        end
                        KIND_COMPLETE: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_HEAD;
                            end else begin
                                w_raddr = '0;
                                n_state = S_POP_HEAD;
                            end
                        end
                        KIND_READ: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_HEAD;
                            end else begin
                                w_raddr = w_rd_idx[AW-1:0];
                                n_state = S_RD_WAIT;
                            end
                        end
                        KIND_RELOAD: begin
                            n_state = S_HEAD;
                        end
                    endcase
                end
            end
            // Start the insert scan from the tail
            S_INS: begin
                n_k     = r_count;
                w_raddr = (r_count != '0) ? w_cm1[AW-1:0] : '0;
                n_state = S_SHIFT;
            end
            // Move later entries up one place, drop the new event into the gap
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                if (r_k != '0 && r_q.ev_time > r_new.ev_time) begin
                    w_wdata = r_q;
                    n_k     = w_km1;
                    w_raddr = (r_k >= CW'(2)) ? w_km2[AW-1:0] : '0;
                end else begin
                    w_wdata = r_new;
                    n_pos   = 8'(r_k);
                    n_count = r_count + CW'(1);
                    n_state = S_HEAD;
                end
            end
            // Capture the removed head
            S_POP_HEAD: begin
                n_rd    = r_q;
                n_k     = CW'(1);
                w_raddr = AW'(1);
                n_state = S_POP;
            end
            // Move every remaining entry down one place
            S_POP: begin
                if (r_k < r_count) begin
                    w_we    = 1'b1;
                    w_waddr = w_km1[AW-1:0];
                    w_wdata = r_q;
                    n_k     = w_kp1;
                    w_raddr = (w_kp1 < r_count) ? w_kp1[AW-1:0] : '0;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = (r_rd.ev_rep != '0) ? S_MUL : S_HEAD;
                end
            end
            // Repeat period in seconds
            S_MUL: begin
                n_prod  = PROD_W'(r_rd.ev_rep) * PROD_W'(SECONDS_PER_DAY);
                n_state = S_ADD;
            end
            // Next occurrence, wrapping at 32 bits
            S_ADD: begin
                n_new.ev_time  = r_rd.ev_time + 32'(r_prod);
                n_new.ev_depth = r_rd.ev_depth;
                n_new.ev_rep   = r_rd.ev_rep;
                n_state        = S_INS;
            end
            S_RD_WAIT: begin
                n_rd    = r_q;
                n_state = S_HEAD;
            end
            // Fetch the head for the report
            S_HEAD: begin
                w_raddr = '0;
                n_state = S_DONE;
            end
            // Hold the report until the output side takes it
            S_DONE: begin
                if (i_rsp_ready) begin
                    o_rsp.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_rsp.status          = r_status;
        o_rsp.insert_position = r_is_add ? r_pos : 8'd0;
        o_rsp.head_time       = (r_count != '0) ? r_q.ev_time : 32'd0;
        o_rsp.rd_entry        = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
        end
        r_new    <= n_new;
        r_rd     <= n_rd;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_is_add <= n_is_add;
        r_prod   <= n_prod;
    end

endmodule
